// ===== hdl/lctt_pkg.sv =====
// Shared types, sizes and codes for the link count tally table.
package lctt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int KEY_W = 64;
  localparam int CNT_W = 32;
  localparam int FOLD_N = (KEY_W + IDX_W - 1) / IDX_W;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    REQ_SET  = 2'd0,
    REQ_INC  = 2'd1,
    REQ_DEC  = 2'd2,
    REQ_NONE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_ALREADY_SET = 2'd1,
    STS_FULL        = 2'd2,
    STS_NOT_FOUND   = 2'd3
  } status_t;

  typedef struct packed {
    key_t key;
    cnt_t recorded;
    cnt_t counted;
  } entry_t;

  // XOR-folds the key down to an index and brings it into the table range.
  function automatic idx_t hash_idx(input key_t key);
    logic [FOLD_N*IDX_W-1:0] ext;
    idx_t fold;
    ext  = (FOLD_N*IDX_W)'(key);
    fold = '0;
    for (int i = 0; i < FOLD_N; i++) begin
      fold = fold ^ ext[i*IDX_W +: IDX_W];
    end
    if ({1'b0, fold} >= (IDX_W+1)'(TABLE_ENTRIES)) begin
      fold = fold - IDX_W'(TABLE_ENTRIES);
    end
    return fold;
  endfunction

endpackage

// ===== hdl/lctt_if.sv =====
// Channel interfaces for requests and results of the link count tally table.
interface lctt_req_if import lctt_pkg::*; ();
  logic      valid;
  logic      ready;
  req_kind_t req_type;
  key_t      object_number;
  cnt_t      new_link_count;

  modport source (output valid, output req_type, output object_number,
                  output new_link_count, input ready);
  modport sink (input valid, input req_type, input object_number,
                input new_link_count, output ready);
endinterface

interface lctt_res_if import lctt_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  cnt_t    recorded_count;
  cnt_t    link_tally;

  modport source (output valid, output status, output recorded_count,
                  output link_tally, input ready);
  modport sink (input valid, input status, input recorded_count,
                input link_tally, output ready);
endinterface

// ===== hdl/link_count_tally_table.sv =====
// Top level of the link count tally table: hashed store with linear probing.
//
//   channel   direction  beat contents
//   in_ch     sink       req_type, object_number, new_link_count
//   out_ch    source     status, recorded_count, link_tally
//
// After a request is accepted the sequencer probes P slots (1 to TABLE_ENTRIES),
// each probe being a read of the entry memory (ST_READ) followed by a compare
// (ST_CMP); ST_RESULT then loads the result into the output register. The next
// request is accepted once the sequencer is back in ST_IDLE. The unused request
// kind skips probing and goes straight to ST_RESULT.
// Reset (rst_n low, synchronous) clears the sequencer, the output valid flag and
// every entry valid bit at once; key and count storage is not cleared.
// A result beat waits in the output register while out_ch.ready is low; a new
// request is taken once the sequencer is back in idle, even if that beat waits.
module link_count_tally_table import lctt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lctt_req_if.sink   in_ch,
  lctt_res_if.source out_ch
);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Latched request.
  req_kind_t kind_r;
  key_t      key_r;
  cnt_t      count_r;

  // Probe position and the number of slots already passed over.
  idx_t probe_addr_r, probe_addr_nxt;
  idx_t probe_cnt_r, probe_cnt_nxt;

  // Entry storage: valid bits in flops, payload in a memory.
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t                   mem [TABLE_ENTRIES];
  entry_t                   rd_data_r;
  logic                     wr_en;
  entry_t                   wr_data;
  logic                     set_valid;

  // Pending result, then the output register.
  status_t res_status_r, res_status_nxt;
  cnt_t    res_rec_r, res_rec_nxt;
  cnt_t    res_cnt_r, res_cnt_nxt;

  logic    out_valid_r;
  status_t out_status_r;
  cnt_t    out_rec_r;
  cnt_t    out_cnt_r;

  logic in_fire;
  logic out_free;
  logic slot_valid;
  logic hit;
  logic last_probe;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign slot_valid = valid_r[probe_addr_r];
  assign hit        = slot_valid && (rd_data_r.key == key_r);
  assign last_probe = (probe_cnt_r == IDX_W'(TABLE_ENTRIES - 1));

  // Sequencer and the shared compare/update step.
  always_comb begin
    state_nxt      = state_r;
    probe_addr_nxt = probe_addr_r;
    probe_cnt_nxt  = probe_cnt_r;
    res_status_nxt = res_status_r;
    res_rec_nxt    = res_rec_r;
    res_cnt_nxt    = res_cnt_r;
    wr_en          = 1'b0;
    wr_data        = rd_data_r;
    set_valid      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          probe_addr_nxt = hash_idx(in_ch.object_number);
          probe_cnt_nxt  = '0;
          if (in_ch.req_type == REQ_NONE) begin
            res_status_nxt = STS_NOT_FOUND;
            res_rec_nxt    = '0;
            res_cnt_nxt    = '0;
            state_nxt      = ST_RESULT;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end

      ST_READ: begin
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        res_status_nxt = STS_OK;
        res_rec_nxt    = '0;
        res_cnt_nxt    = '0;
        state_nxt      = ST_RESULT;
        if (hit) begin
          case (kind_r)
            REQ_SET: begin
              if (rd_data_r.recorded != '0) begin
                res_status_nxt = STS_ALREADY_SET;
              end else begin
                wr_data.recorded = count_r;
                wr_en            = 1'b1;
              end
            end
            REQ_INC: begin
              wr_data.counted = rd_data_r.counted + 1'b1;
              wr_en           = 1'b1;
            end
            REQ_DEC: begin
              wr_data.counted = rd_data_r.counted - 1'b1;
              wr_en           = 1'b1;
            end
            default: begin
              res_status_nxt = STS_NOT_FOUND;
            end
          endcase
        end else if (!slot_valid) begin
          // An empty slot ends the probe chain: the key is absent.
          wr_data.key = key_r;
          case (kind_r)
            REQ_SET: begin
              wr_data.recorded = count_r;
              wr_data.counted  = '0;
              wr_en            = 1'b1;
              set_valid        = 1'b1;
            end
            REQ_INC: begin
              wr_data.recorded = '0;
              wr_data.counted  = CNT_W'(1);
              wr_en            = 1'b1;
              set_valid        = 1'b1;
            end
            default: begin
              res_status_nxt = STS_NOT_FOUND;
            end
          endcase
        end else if (last_probe) begin
          // Every slot holds another key.
          res_status_nxt = (kind_r == REQ_DEC) ? STS_NOT_FOUND : STS_FULL;
        end else begin
          probe_addr_nxt = (probe_addr_r == IDX_W'(TABLE_ENTRIES - 1)) ?
                           '0 : probe_addr_r + 1'b1;
          probe_cnt_nxt  = probe_cnt_r + 1'b1;
          state_nxt      = ST_READ;
        end
        if (wr_en) begin
          res_rec_nxt = wr_data.recorded;
          res_cnt_nxt = wr_data.counted;
        end
      end

      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (set_valid) begin
        valid_r[probe_addr_r] <= 1'b1;
      end
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= in_ch.req_type;
      key_r   <= in_ch.object_number;
      count_r <= in_ch.new_link_count;
    end
    probe_addr_r <= probe_addr_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    res_status_r <= res_status_nxt;
    res_rec_r    <= res_rec_nxt;
    res_cnt_r    <= res_cnt_nxt;
    if (state_r == ST_RESULT && out_free) begin
      out_status_r <= res_status_r;
      out_rec_r    <= res_rec_r;
      out_cnt_r    <= res_cnt_r;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[probe_addr_r] <= wr_data;
    end
    rd_data_r <= mem[probe_addr_r];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.recorded_count = out_rec_r;
  assign out_ch.link_tally     = out_cnt_r;

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the link count tally table: directed and random requests checked by a predictor.
module tb_top;
  import lctt_pkg::*;

  // The slowest request is one that probes every slot.
  localparam int WORST_LATENCY = 2 + 2 * TABLE_ENTRIES;

  // Random traffic keeps the table at or below this fill level, so that probe runs
  // stay short; the table-full test later fills every slot.
  localparam int RANDOM_FILL_CAP = 200;

  // Number of requests in each leg of the random traffic.
  localparam int IDLE_LEG_A = 600;
  localparam int BUSY_LEG   = 300;
  localparam int IDLE_LEG_B = 550;

  // A hung block ends the run here. This is several times the slowest correct run.
  localparam int RUN_LIMIT = 20_000_000;

  typedef struct packed {
    status_t status;
    cnt_t    recorded;
    cnt_t    counted;
  } tally_t;

  logic clk;
  logic rst_n;

  lctt_req_if req_ch ();
  lctt_res_if res_ch ();

  link_count_tally_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Predictor state. The block's slot placement is invisible from outside,
  // so the table is held by key. An insert is refused once the number of
  // live keys reaches TABLE_ENTRIES.
  cnt_t recorded_of [key_t];
  cnt_t links_of [key_t];
  key_t known_keys[$];

  // Expected result beats, oldest first.
  tally_t due_tallies[$];

  bit     idling_on;
  int     mismatches;
  int     sent_beats;
  int     status_hits [4];
  tally_t want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Works out the result of one accepted request and updates the predicted table.
  function automatic void predict_request(req_kind_t kind, key_t key, cnt_t count);
    tally_t res;
    bit     hit;
    bit     full;
    hit  = recorded_of.exists(key);
    full = (known_keys.size() >= TABLE_ENTRIES);
    res  = '{status: STS_OK, recorded: '0, counted: '0};
    case (kind)
      REQ_SET: begin
        if (hit) begin
          // A set may only land on an entry whose recorded count is still zero.
          if (recorded_of[key] != '0) res.status = STS_ALREADY_SET;
          else recorded_of[key] = count;
        end else if (full) begin
          res.status = STS_FULL;
        end else begin
          recorded_of[key] = count;
          links_of[key]    = '0;
          known_keys.push_back(key);
        end
      end
      REQ_INC: begin
        if (hit) begin
          links_of[key] = links_of[key] + 1'b1;
        end else if (full) begin
          res.status = STS_FULL;
        end else begin
          recorded_of[key] = '0;
          links_of[key]    = 1;
          known_keys.push_back(key);
        end
      end
      REQ_DEC: begin
        // A decrement never inserts; a miss is reported and nothing changes.
        if (hit) links_of[key] = links_of[key] - 1'b1;
        else res.status = STS_NOT_FOUND;
      end
      default: begin
        res.status = STS_NOT_FOUND;
      end
    endcase
    if (res.status == STS_OK) begin
      res.recorded = recorded_of[key];
      res.counted  = links_of[key];
    end
    due_tallies.push_back(res);
  endfunction

  function automatic key_t fresh_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic key_t pick_known_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  // Flipping the same byte pattern in two byte lanes leaves the XOR fold of the
  // key unchanged, so the result lands on the same home slot and forces probing.
  function automatic key_t twin_key(key_t key);
    int        lane_a;
    int        lane_b;
    logic [7:0] pat;
    lane_a = $urandom_range(0, 7);
    lane_b = (lane_a + $urandom_range(1, 7)) % 8;
    pat    = 8'($urandom_range(1, 255));
    return key ^ (key_t'(pat) << (8 * lane_a)) ^ (key_t'(pat) << (8 * lane_b));
  endfunction

  function automatic cnt_t rand_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return cnt_t'($urandom_range(1, 3));
      default: return $urandom();
    endcase
  endfunction

  // Presents one request beat and holds it until the block takes it. Valid is
  // left high on return, so back-to-back beats keep it high unless idling_on drops it.
  task automatic send_request(req_kind_t kind, key_t key, cnt_t count);
    while (idling_on && $urandom_range(0, 99) < 34) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= kind;
    req_ch.object_number  <= key;
    req_ch.new_link_count <= count;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(kind, key, count);
    sent_beats++;
  endtask

  // Holds off the sender until every predicted result beat has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (due_tallies.size() != 0) @(posedge clk);
  endtask

  // Basic operation on a single entry at the extreme key and count values,
  // including wrap of the counted links in both directions.
  task automatic test_single_entry();
    send_request(REQ_SET, '0, '1);        // miss inserts with the largest count
    send_request(REQ_SET, '0, 32'd9);     // recorded count is nonzero: refused
    send_request(REQ_INC, '0, '0);
    send_request(REQ_DEC, '0, '1);
    send_request(REQ_DEC, '0, '0);        // zero goes down to all ones
    send_request(REQ_INC, '0, '0);        // all ones goes up to zero
  endtask

  // Inserts through increment, sets on a zero recorded count, decrement
  // misses, and the unused request kind.
  task automatic test_insert_paths();
    key_t probe;
    probe = fresh_key();
    send_request(REQ_INC, '1, '1);        // miss inserts counted links of one
    send_request(REQ_SET, '1, '0);        // zero onto zero is accepted
    send_request(REQ_SET, '1, '0);        // and still accepted afterwards
    send_request(REQ_SET, '1, 32'h8000_0001);
    send_request(REQ_SET, '1, 32'h1);     // now refused
    send_request(REQ_DEC, probe, '1);     // miss: not found, no insert
    send_request(REQ_DEC, probe, '0);     // still a miss
    send_request(REQ_NONE, '1, '1);       // unused kind on a live key
    send_request(REQ_NONE, probe, '0);    // and on an absent one
    send_request(REQ_INC, '1, '0);        // shows the live entry unchanged
  endtask

  // Several keys that share one home slot, so lookups must walk past others.
  task automatic test_shared_home();
    key_t base;
    key_t twin_a;
    key_t twin_b;
    base   = 64'h0123_4567_89AB_CDEF;
    twin_a = base ^ 64'h0000_0000_0000_FFFF;
    twin_b = base ^ 64'hA500_0000_00A5_0000;
    send_request(REQ_INC, base, '0);
    send_request(REQ_SET, twin_a, 32'h5555_AAAA);
    send_request(REQ_INC, twin_b, '0);
    send_request(REQ_DEC, twin_a, '0);
    send_request(REQ_INC, twin_b, '0);
    send_request(REQ_SET, base, 32'hAAAA_5555);
    send_request(REQ_DEC, twin_b ^ 64'h0000_0000_0000_3C3C, '0);
  endtask

  // Random mix of all request kinds. Most keys are already in the table, some
  // share a home slot with one that is, and the rest are new.
  task automatic test_random_traffic(int count);
    for (int n = 0; n < count; n++) begin
      int        pick;
      int        kind_roll;
      req_kind_t kind;
      key_t      key;
      pick      = $urandom_range(0, 99);
      kind_roll = $urandom_range(0, 99);
      if (kind_roll < 32) kind = REQ_SET;
      else if (kind_roll < 70) kind = REQ_INC;
      else if (kind_roll < 95) kind = REQ_DEC;
      else kind = REQ_NONE;
      if (known_keys.size() == 0 || pick >= 85) key = fresh_key();
      else if (pick >= 70) key = twin_key(pick_known_key());
      else key = pick_known_key();
      // Keep the table short of full here; only inserting kinds can grow it.
      if ((kind == REQ_SET || kind == REQ_INC) && !recorded_of.exists(key) &&
          known_keys.size() >= RANDOM_FILL_CAP) begin
        key = pick_known_key();
      end
      send_request(kind, key, rand_count());
    end
  endtask

  // Fills every slot, then checks that inserts are refused while the live
  // entries keep working.
  task automatic test_table_full();
    key_t key;
    while (known_keys.size() < TABLE_ENTRIES) begin
      if ($urandom_range(0, 1)) send_request(REQ_INC, fresh_key(), rand_count());
      else send_request(REQ_SET, twin_key(pick_known_key()), rand_count());
    end
    send_request(REQ_SET, fresh_key(), '1);
    send_request(REQ_INC, fresh_key(), '0);
    send_request(REQ_DEC, fresh_key(), '0);
    send_request(REQ_INC, pick_known_key(), '0);
    send_request(REQ_SET, pick_known_key(), rand_count());
    for (int n = 0; n < 20; n++) begin
      key = ($urandom_range(0, 1)) ? pick_known_key() : twin_key(pick_known_key());
      send_request(req_kind_t'($urandom_range(0, 3)), key, rand_count());
    end
  endtask

  // Result side: the ready line stalls at random while idling_on is set, and every
  // beat taken is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    res_ch.ready <= !(idling_on && $urandom_range(0, 99) < 34);
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (due_tallies.size() == 0) begin
        $error("result beat with no request outstanding: status %0d", res_ch.status);
        mismatches++;
      end else begin
        want = due_tallies.pop_front();
        status_hits[want.status]++;
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          mismatches++;
        end
        if (res_ch.recorded_count !== want.recorded) begin
          $error("recorded_count: expected %0d, got %0d", want.recorded,
                 res_ch.recorded_count);
          mismatches++;
        end
        if (res_ch.link_tally !== want.counted) begin
          $error("link_tally: expected %0d, got %0d", want.counted,
                 res_ch.link_tally);
          mismatches++;
        end
      end
    end
  end

  initial begin
    // Every request input is known from the start; reset is held low before the tests.
    rst_n                 <= 1'b0;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_SET;
    req_ch.object_number  <= '0;
    req_ch.new_link_count <= '0;
    idling_on = 1'b1;
    mismatches = 0;
    sent_beats = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_single_entry();
    test_insert_paths();
    test_shared_home();
    wait_drained();

    test_random_traffic(IDLE_LEG_A);
    // A stretch at full rate on both sides.
    idling_on = 1'b0;
    test_random_traffic(BUSY_LEG);
    idling_on = 1'b1;
    wait_drained();
    test_random_traffic(IDLE_LEG_B);
    wait_drained();

    test_table_full();
    wait_drained();
    // Any stray beat after the last expected one would show up in this window.
    repeat (WORST_LATENCY + 16) @(posedge clk);

    $display("Ran %0d requests over a table that ended with %0d of %0d entries live.",
             sent_beats, known_keys.size(), TABLE_ENTRIES);
    $display("Results seen: %0d ok, %0d already set, %0d table full, %0d not found.",
             status_hits[STS_OK], status_hits[STS_ALREADY_SET], status_hits[STS_FULL],
             status_hits[STS_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
